// ===== hdl/crcrd_pkg.sv =====
package crcrd_pkg;

    localparam int RecBytes  = 16;
    localparam int BodyBytes = 12;
    localparam int PosW      = 4;

    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'hA001;
    localparam logic [7:0]  MARK_0   = 8'hA5;
    localparam logic [7:0]  MARK_1   = 8'h5A;

    // Byte positions inside a record that have their own meaning.
    localparam logic [PosW-1:0] POS_CRC_LO = 4'd12;
    localparam logic [PosW-1:0] POS_CRC_HI = 4'd13;
    localparam logic [PosW-1:0] POS_MARK_0 = 4'd14;
    localparam logic [PosW-1:0] POS_MARK_1 = 4'd15;

    typedef logic [PosW-1:0] pos_t;

    // One byte as it waits in the input register.
    typedef struct packed {
        logic [7:0] data_byte;
        logic       record_start;
    } in_item_t;

    // Decoded record as it leaves the block.
    typedef struct packed {
        logic        [31:0] time_ms;
        logic        [7:0]  kind;
        logic        [7:0]  flags;
        logic signed [15:0] param_a;
        logic        [15:0] param_b;
        logic        [15:0] param_c;
        logic               valid_res;
    } rec_t;

    // CRC-16/MODBUS update by one byte, reflected form, LSB first.
    function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int i = 0; i < 8; i++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

// ===== hdl/crcrd_in_stage.sv =====
module crcrd_in_stage (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  crcrd_pkg::in_item_t s_item,
    input  logic                advance,
    output logic                item_valid,
    output crcrd_pkg::in_item_t item
);
    import crcrd_pkg::*;

    logic     valid_reg;
    logic     valid_next;
    in_item_t item_reg;

    // The register can take a new byte when it is empty or is emptied this cycle.
    assign s_ready = !valid_reg || advance;

    always_comb begin
        valid_next = valid_reg;
        if (s_ready) begin
            valid_next = s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            item_reg <= s_item;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

// ===== hdl/crcrd_check.sv =====
module crcrd_check (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                en,
    input  crcrd_pkg::in_item_t item,
    output logic                emit,
    output crcrd_pkg::rec_t     rec
);
    import crcrd_pkg::*;

    pos_t        pos_reg;
    logic [15:0] crc_reg;
    logic [15:0] rx_crc_reg;
    logic        magic_ok_reg;
    logic [7:0]  body_reg [BodyBytes];

    pos_t        pos;
    logic        in_body;
    logic [15:0] crc_next;
    logic        ok;

    // A start mark forces position zero; otherwise the position just counts.
    assign pos     = item.record_start ? '0 : pos_reg;
    assign in_body = (pos < pos_t'(BodyBytes));
    assign crc_next = crc_byte((pos == '0) ? CRC_INIT : crc_reg, item.data_byte);
    assign emit    = (pos == POS_MARK_1);

    assign ok = magic_ok_reg && (item.data_byte == MARK_1) && (rx_crc_reg == crc_reg);

    always_comb begin
        rec = '0;
        if (ok) begin
            rec.time_ms   = {body_reg[3], body_reg[2], body_reg[1], body_reg[0]};
            rec.kind      = body_reg[4];
            rec.flags     = body_reg[5];
            rec.param_a   = {body_reg[7], body_reg[6]};
            rec.param_b   = {body_reg[9], body_reg[8]};
            rec.param_c   = {body_reg[11], body_reg[10]};
            rec.valid_res = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg      <= '0;
            crc_reg      <= CRC_INIT;
            rx_crc_reg   <= '0;
            magic_ok_reg <= 1'b0;
        end else if (en) begin
            pos_reg <= pos + pos_t'(1);
            if (in_body) begin
                crc_reg <= crc_next;
            end
            if (pos == POS_CRC_LO) begin
                rx_crc_reg[7:0] <= item.data_byte;
            end
            if (pos == POS_CRC_HI) begin
                rx_crc_reg[15:8] <= item.data_byte;
            end
            if (pos == POS_MARK_0) begin
                magic_ok_reg <= (item.data_byte == MARK_0);
            end
        end
    end

    always_ff @(posedge aclk) begin
        for (int i = 0; i < BodyBytes; i++) begin
            if (en && (pos == pos_t'(i))) begin
                body_reg[i] <= item.data_byte;
            end
        end
    end

endmodule

// ===== hdl/crc_checked_record_decoder.sv =====
// Journal record checker for a byte stream of 16-byte records.
// Bytes enter on the s_ channel, one transfer per byte, with s_record_start
// marking byte 0 of a record; without a mark the position simply counts and
// wraps, so back-to-back records need no mark. A mark in mid-record drops the
// partial record silently.
// On byte 15 of each record one transfer leaves on the m_ channel with the
// decoded fields and m_valid_res. m_valid_res is high only when bytes 14-15
// hold the marker 0xA5, 0x5A and bytes 12-13 hold the CRC-16/MODBUS of bytes
// 0-11; for a bad record all field ports read zero.
// Byte 15 passes the input register and then the result register, which
// raises m_valid; a full, undrained result register holds it back. One
// byte is taken every cycle while the result register is free or drained;
// the CRC byte update is combinational from the input register to crc_reg.
// Reset (aresetn low, synchronous) empties both registers, sets the byte
// position to zero and the CRC to 0xFFFF.
// When the receiver holds m_ready low, the result register keeps its record,
// the input register fills, and s_ready falls until m_ready returns; nothing
// is lost or repeated.
module crc_checked_record_decoder (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic        [7:0]  s_data_byte,
    input  logic               s_record_start,
    output logic               m_valid,
    input  logic               m_ready,
    output logic        [31:0] m_time_ms,
    output logic        [7:0]  m_kind,
    output logic        [7:0]  m_flags,
    output logic signed [15:0] m_param_a,
    output logic        [15:0] m_param_b,
    output logic        [15:0] m_param_c,
    output logic               m_valid_res
);
    import crcrd_pkg::*;

    in_item_t s_item;
    in_item_t item;
    logic     item_valid;
    logic     advance;
    logic     emit;
    rec_t     rec;

    logic     m_valid_reg;
    logic     m_valid_next;
    rec_t     rec_reg;

    assign s_item.data_byte    = s_data_byte;
    assign s_item.record_start = s_record_start;

    // A held byte moves on whenever the result register is free or being
    // drained; bytes that produce no result move on under the same rule.
    assign advance = item_valid && (!m_valid_reg || m_ready);

    crcrd_in_stage u_in (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_item     (s_item),
        .advance    (advance),
        .item_valid (item_valid),
        .item       (item)
    );

    crcrd_check u_check (
        .aclk    (aclk),
        .aresetn (aresetn),
        .en      (advance),
        .item    (item),
        .emit    (emit),
        .rec     (rec)
    );

    always_comb begin
        m_valid_next = m_valid_reg;
        if (advance) begin
            m_valid_next = emit;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    // The result is only loaded on the byte that completes a record.
    always_ff @(posedge aclk) begin
        if (advance && emit) begin
            rec_reg <= rec;
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_time_ms   = rec_reg.time_ms;
    assign m_kind      = rec_reg.kind;
    assign m_flags     = rec_reg.flags;
    assign m_param_a   = rec_reg.param_a;
    assign m_param_b   = rec_reg.param_b;
    assign m_param_c   = rec_reg.param_c;
    assign m_valid_res = rec_reg.valid_res;

endmodule

// ===== tb/sv/tb_crc_checked_record_decoder.sv =====
module tb_crc_checked_record_decoder;

    import crcrd_pkg::*;

    // Predicts the decoded record for every byte transfer and holds the
    // records still waiting to leave the block, oldest first.
    class journal_record_board;
        pos_t       next_pos;
        logic [15:0] body_crc;
        logic [7:0]  body [BodyBytes];
        logic [15:0] sent_crc;
        logic        mark_seen;
        rec_t        waiting_records [$];
        int          fails;

        function new();
            next_pos  = '0;
            body_crc  = CRC_INIT;
            sent_crc  = '0;
            mark_seen = 1'b0;
            fails     = 0;
            foreach (body[i]) body[i] = '0;
        endfunction

        // Bit-serial CRC-16/MODBUS step over one byte.
        static function logic [15:0] crc16_step(logic [15:0] crc, logic [7:0] d);
            logic [15:0] c;
            logic        fb;
            c = crc;
            for (int i = 0; i < 8; i++) begin
                fb = c[0] ^ d[i];
                c  = c >> 1;
                if (fb) c = c ^ CRC_POLY;
            end
            return c;
        endfunction

        function void take_byte(logic [7:0] d, logic start);
            pos_t pos;
            rec_t rec;
            logic good;
            pos = start ? pos_t'(0) : next_pos;
            if (pos < pos_t'(BodyBytes)) begin
                body[pos] = d;
                body_crc  = crc16_step((pos == pos_t'(0)) ? CRC_INIT : body_crc, d);
            end else begin
                case (pos)
                    POS_CRC_LO: sent_crc[7:0]  = d;
                    POS_CRC_HI: sent_crc[15:8] = d;
                    POS_MARK_0: mark_seen      = (d == MARK_0);
                    default: begin
                        good = mark_seen && (d == MARK_1) && (sent_crc == body_crc);
                        rec  = '0;
                        if (good) begin
                            rec.time_ms   = {body[3], body[2], body[1], body[0]};
                            rec.kind      = body[4];
                            rec.flags     = body[5];
                            rec.param_a   = {body[7], body[6]};
                            rec.param_b   = {body[9], body[8]};
                            rec.param_c   = {body[11], body[10]};
                            rec.valid_res = 1'b1;
                        end
                        waiting_records.push_back(rec);
                    end
                endcase
            end
            next_pos = pos + pos_t'(1);
        endfunction

        function void compare_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
            if (exp_v !== act_v) begin
                $error("%s: expected %h, actual %h", name, exp_v, act_v);
                fails++;
            end
        endfunction

        function void check_record(rec_t got);
            rec_t exp_r;
            if (waiting_records.size() == 0) begin
                $error("record transfer with no record expected");
                fails++;
                return;
            end
            exp_r = waiting_records.pop_front();
            compare_field("time_ms", exp_r.time_ms, got.time_ms);
            compare_field("kind", {24'h0, exp_r.kind}, {24'h0, got.kind});
            compare_field("flags", {24'h0, exp_r.flags}, {24'h0, got.flags});
            compare_field("param_a", {16'h0, exp_r.param_a}, {16'h0, got.param_a});
            compare_field("param_b", {16'h0, exp_r.param_b}, {16'h0, got.param_b});
            compare_field("param_c", {16'h0, exp_r.param_c}, {16'h0, got.param_c});
            compare_field("valid_res", {31'h0, exp_r.valid_res}, {31'h0, got.valid_res});
        endfunction
    endclass

    logic               aclk;
    logic               aresetn;
    logic               s_valid;
    logic               s_ready;
    logic        [7:0]  s_data_byte;
    logic               s_record_start;
    logic               m_valid;
    logic               m_ready;
    logic        [31:0] m_time_ms;
    logic        [7:0]  m_kind;
    logic        [7:0]  m_flags;
    logic signed [15:0] m_param_a;
    logic        [15:0] m_param_b;
    logic        [15:0] m_param_c;
    logic               m_valid_res;

    crc_checked_record_decoder dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_data_byte    (s_data_byte),
        .s_record_start (s_record_start),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_time_ms      (m_time_ms),
        .m_kind         (m_kind),
        .m_flags        (m_flags),
        .m_param_a      (m_param_a),
        .m_param_b      (m_param_b),
        .m_param_c      (m_param_c),
        .m_valid_res    (m_valid_res)
    );

    journal_record_board board = new();

    // One complete 16-byte record as it goes on the wire.
    logic [7:0] frame [RecBytes];

    // Number of byte transfers so far, and the switch that turns off all
    // idling on both sides for the tail of the run.
    int bytes_sent = 0;
    bit quiet      = 1'b0;
    // Percent chance of a sender gap before each byte; changed per record.
    int gap_odds   = 0;

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Hard stop in case the block hangs on a handshake.
    initial begin
        #3000000;
        $display("CHECK FAILED");
        $finish;
    end

    // Every input transfer is handed to the predictor and every output
    // transfer is checked against the oldest predicted record. All testbench
    // drives after time zero are nonblocking, so both sides are seen with
    // their values from before the edge. The input is noted first, which keeps
    // the order right even if a record and a byte move at the same edge.
    always @(posedge aclk) begin
        rec_t got;
        if (aresetn) begin
            if (s_valid && s_ready) begin
                board.take_byte(s_data_byte, s_record_start);
                bytes_sent++;
            end
            if (m_valid && m_ready) begin
                got.time_ms   = m_time_ms;
                got.kind      = m_kind;
                got.flags     = m_flags;
                got.param_a   = m_param_a;
                got.param_b   = m_param_b;
                got.param_c   = m_param_c;
                got.valid_res = m_valid_res;
                board.check_record(got);
            end
        end
    end

    // Receiver: m_ready drops in bursts of random length. The stall rate is
    // redrawn periodically, and a rate of zero gives stretches in which
    // the receiver never stalls.
    initial begin
        int stall_odds;
        int cycle_count;
        stall_odds  = 0;
        cycle_count = 0;
        m_ready     = 1'b0;
        forever begin
            @(posedge aclk);
            cycle_count++;
            if (cycle_count % 100 == 0) begin
                case ($urandom_range(0, 2))
                    0: stall_odds = 0;
                    1: stall_odds = 6;
                    default: stall_odds = 25;
                endcase
            end
            if (aresetn && !quiet && $urandom_range(0, 99) < stall_odds) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 11)) @(posedge aclk);
            end
            m_ready <= 1'b1;
        end
    end

    // Presents one byte and holds it until the transfer happens. Valid stays
    // high on return so that a following byte can go out on the next edge.
    task automatic send_byte(input logic [7:0] d, input logic start);
        if (!quiet && gap_odds > 0 && $urandom_range(0, 99) < gap_odds) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge aclk);
        end
        s_valid        <= 1'b1;
        s_data_byte    <= d;
        s_record_start <= start;
        do @(posedge aclk); while (!s_ready);
    endtask

    // Fills the frame with a well-formed record: the little-endian body,
    // its CRC low byte first, and the two marker bytes.
    task automatic make_record(input logic [31:0] t, input logic [7:0] k,
                               input logic [7:0] f, input logic [15:0] pa,
                               input logic [15:0] pb, input logic [15:0] pc);
        logic [15:0] crc;
        {frame[3], frame[2], frame[1], frame[0]} = t;
        frame[4] = k;
        frame[5] = f;
        {frame[7], frame[6]}   = pa;
        {frame[9], frame[8]}   = pb;
        {frame[11], frame[10]} = pc;
        crc = CRC_INIT;
        for (int i = 0; i < BodyBytes; i++) begin
            crc = journal_record_board::crc16_step(crc, frame[i]);
        end
        frame[POS_CRC_LO] = crc[7:0];
        frame[POS_CRC_HI] = crc[15:8];
        frame[POS_MARK_0] = MARK_0;
        frame[POS_MARK_1] = MARK_1;
    endtask

    // Sends the first n bytes of the frame; only byte 0 may carry the mark.
    task automatic send_frame(input int n, input logic mark);
        for (int i = 0; i < n; i++) begin
            send_byte(frame[i], (i == 0) ? mark : 1'b0);
        end
    endtask

    // Field values lean toward zero, all ones and the sign bit.
    function automatic logic [31:0] pick_value(input int bits);
        logic [31:0] mask;
        mask = (bits == 32) ? 32'hFFFF_FFFF : ((32'd1 << bits) - 1);
        case ($urandom_range(0, 5))
            0: return 32'h0;
            1: return mask;
            2: return 32'd1 << (bits - 1);
            default: return $urandom() & mask;
        endcase
    endfunction

    task automatic random_record();
        make_record(pick_value(32), 8'(pick_value(8)), 8'(pick_value(8)),
                    16'(pick_value(16)), 16'(pick_value(16)), 16'(pick_value(16)));
    endtask

    initial begin
        int  choice;
        int  flip_at;
        bit  aligned;
        aresetn        = 1'b0;
        s_valid        = 1'b0;
        s_data_byte    = 8'h00;
        s_record_start = 1'b0;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed part. The first record is all zeros with a start mark,
        // and the next follows back to back with no mark, so the position
        // wrap alone must frame it.
        make_record(32'h0, 8'h00, 8'h00, 16'h0000, 16'h0000, 16'h0000);
        send_frame(RecBytes, 1'b1);
        make_record(32'hFFFF_FFFF, 8'hFF, 8'hFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_frame(RecBytes, 1'b0);
        make_record(32'h8000_0001, 8'h80, 8'h01, 16'h8000, 16'h7FFF, 16'h0001);
        send_frame(RecBytes, 1'b0);

        // A record whose CRC does not match must come out invalid with all
        // fields at zero.
        make_record(32'h1234_5678, 8'h11, 8'h22, 16'h7FFF, 16'hBEEF, 16'hCAFE);
        frame[POS_CRC_LO] = frame[POS_CRC_LO] ^ 8'h01;
        send_frame(RecBytes, 1'b0);

        // Bad first marker byte, then bad second marker byte.
        make_record(32'h0BAD_F00D, 8'h33, 8'h44, 16'h8001, 16'h0102, 16'h0304);
        frame[POS_MARK_0] = 8'hA4;
        send_frame(RecBytes, 1'b0);
        make_record(32'h0BAD_F00D, 8'h33, 8'h44, 16'h8001, 16'h0102, 16'h0304);
        frame[POS_MARK_1] = 8'hDA;
        send_frame(RecBytes, 1'b0);

        // Resynchronization: a record cut off after 15 bytes emits nothing
        // once a start mark arrives, and the marked record decodes cleanly.
        make_record(32'hDEAD_BEEF, 8'h5A, 8'hA5, 16'hFFFE, 16'h8000, 16'h00FF);
        send_frame(RecBytes - 1, 1'b0);
        make_record(32'h0000_0100, 8'h02, 8'h04, 16'h0080, 16'hFF00, 16'h8080);
        send_frame(RecBytes, 1'b1);

        // Random part. Most records are well formed with random contents so
        // that the decode and the valid path are exercised hard; the rest
        // are damaged records, cut-off records and raw noise.
        aligned = 1'b1;
        while (bytes_sent < 1500) begin
            if (bytes_sent >= 1300) quiet = 1'b1;
            case ($urandom_range(0, 3))
                0: gap_odds = 0;
                1: gap_odds = 5;
                default: gap_odds = 20;
            endcase
            choice = $urandom_range(0, 99);
            random_record();
            if (choice < 65) begin
                send_frame(RecBytes, aligned ? 1'($urandom_range(0, 1)) : 1'b1);
                aligned = 1'b1;
            end else if (choice < 80) begin
                // One flipped bit anywhere breaks the CRC or a marker.
                flip_at = $urandom_range(0, RecBytes - 1);
                frame[flip_at] = frame[flip_at] ^ (8'h01 << $urandom_range(0, 7));
                send_frame(RecBytes, aligned ? 1'($urandom_range(0, 1)) : 1'b1);
                aligned = 1'b1;
            end else if (choice < 90) begin
                send_frame($urandom_range(1, RecBytes - 1), 1'b1);
                aligned = 1'b0;
            end else begin
                repeat ($urandom_range(1, 20)) begin
                    send_byte(8'($urandom()), ($urandom_range(0, 7) == 0));
                end
                aligned = 1'b0;
            end
        end
        s_valid        <= 1'b0;
        s_record_start <= 1'b0;

        // Drain: wait for every predicted record, then keep running so that
        // a stray extra transfer would still be caught.
        while (board.waiting_records.size() != 0) @(posedge aclk);
        repeat (10) @(posedge aclk);

        if (board.fails == 0 && board.waiting_records.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
